### hdl/spfc_pkg.sv
package spfc_pkg;

  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int ROW_WIDTH_W = 13;
  localparam int POS_W = 12;
  localparam int TOTAL_W = 24;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd640;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

  localparam logic [1:0] CLASS_BLACK = 2'd0;
  localparam logic [1:0] CLASS_OUTLINE = 2'd2;

  typedef struct packed {
    logic [1:0] pixel_class;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic               span_valid;
    logic [POS_W-1:0]   span_row;
    logic [POS_W-1:0]   span_first;
    logic [POS_W-1:0]   span_stop;
    logic [TOTAL_W-1:0] filled_total;
    logic               image_done;
  } result_t;

  typedef struct packed {
    logic prev_was_outline;
    logic entering_flag;
    logic inside_flag;
  } row_flags_t;

endpackage

### hdl/spfc_step.sv
module spfc_step #(
  parameter int MAX_WIDTH = spfc_pkg::MAX_WIDTH_DEFAULT,
  parameter int COL_W = $clog2(MAX_WIDTH)
) (
  input  spfc_pkg::pixel_t                   pixel,
  input  logic [spfc_pkg::ROW_WIDTH_W-1:0]   row_width,
  input  logic [COL_W-1:0]                   column_pos,
  input  logic [spfc_pkg::POS_W-1:0]         row_pos,
  input  spfc_pkg::row_flags_t               flags,
  input  logic [COL_W-1:0]                   open_start,
  input  logic [spfc_pkg::TOTAL_W-1:0]       pixel_total,
  output logic [COL_W-1:0]                   column_pos_next,
  output logic [spfc_pkg::POS_W-1:0]         row_pos_next,
  output spfc_pkg::row_flags_t               flags_next,
  output logic [COL_W-1:0]                   open_start_next,
  output logic [spfc_pkg::TOTAL_W-1:0]       pixel_total_next,
  output logic                               has_result,
  output spfc_pkg::result_t                  result
);

  localparam int CMP_W = (COL_W + 1 > spfc_pkg::ROW_WIDTH_W) ? COL_W + 1
                                                              : spfc_pkg::ROW_WIDTH_W;
  localparam int XW = (COL_W > spfc_pkg::POS_W) ? COL_W : spfc_pkg::POS_W;
  localparam int SUM_W = spfc_pkg::TOTAL_W + 1;
  localparam logic [CMP_W-1:0] WIDTH_MAX = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] WIDTH_MIN = CMP_W'(2);

  logic             outline;
  logic             black;
  logic             prev;
  logic             span;
  logic [CMP_W-1:0] width_raw;
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] column_inc;
  logic [COL_W-1:0] add;
  logic [SUM_W-1:0] sum;
  logic [XW-1:0]    first_x;
  logic [XW-1:0]    stop_x;
  spfc_pkg::row_flags_t flags_upd;
  logic [COL_W-1:0] open_upd;
  logic [spfc_pkg::TOTAL_W-1:0] total_upd;

  always_comb begin
    outline = (pixel.pixel_class == spfc_pkg::CLASS_OUTLINE);
    black = (pixel.pixel_class == spfc_pkg::CLASS_BLACK);
    prev = (column_pos != '0) && flags.prev_was_outline;

    flags_upd = flags;
    open_upd = open_start;
    total_upd = pixel_total;
    span = 1'b0;
    add = '0;
    sum = '0;

    if (outline) begin
      if (flags.inside_flag) begin
        flags_upd.inside_flag = 1'b0;
        flags_upd.entering_flag = 1'b0;
        if (open_start != '0) begin
          span = 1'b1;
          if (column_pos > open_start) begin
            add = column_pos - open_start;
          end
          sum = {1'b0, pixel_total} + SUM_W'(add);
          if (sum > SUM_W'(spfc_pkg::TOTAL_MAX)) begin
            total_upd = spfc_pkg::TOTAL_MAX;
          end else begin
            total_upd = sum[spfc_pkg::TOTAL_W-1:0];
          end
          open_upd = '0;
        end
      end else begin
        flags_upd.entering_flag = 1'b1;
      end
    end

    if (prev && black && flags_upd.entering_flag) begin
      flags_upd.inside_flag = 1'b1;
      open_upd = column_pos;
    end
    flags_upd.prev_was_outline = outline;

    first_x = XW'(open_start);
    stop_x = XW'(column_pos);
    has_result = span || pixel.last_pixel;
    result.span_valid = span;
    result.span_row = span ? row_pos : '0;
    result.span_first = span ? first_x[spfc_pkg::POS_W-1:0] : '0;
    result.span_stop = span ? stop_x[spfc_pkg::POS_W-1:0] : '0;
    result.filled_total = total_upd;
    result.image_done = pixel.last_pixel;

    width_raw = CMP_W'(row_width);
    if (width_raw < WIDTH_MIN) begin
      width_eff = WIDTH_MIN;
    end else if (width_raw > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = width_raw;
    end
    column_inc = CMP_W'(column_pos) + CMP_W'(1);

    column_pos_next = column_inc[COL_W-1:0];
    row_pos_next = row_pos;
    flags_next = flags_upd;
    open_start_next = open_upd;
    pixel_total_next = total_upd;
    if (pixel.last_pixel) begin
      column_pos_next = '0;
      row_pos_next = '0;
      flags_next = '0;
      open_start_next = '0;
      pixel_total_next = '0;
    end else if (column_inc >= width_eff) begin
      column_pos_next = '0;
      row_pos_next = row_pos + spfc_pkg::POS_W'(1);
      flags_next = '0;
      open_start_next = '0;
    end
  end

endmodule

### hdl/spfc_out_buf.sv
module spfc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  spfc_pkg::result_t push_data,
  output logic              space,
  output logic              result_valid,
  input  logic              result_ready,
  output spfc_pkg::result_t result
);

  spfc_pkg::result_t entry [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       pop;

  assign pop = result_valid && result_ready;
  assign space = (count != 2'd2);
  assign result_valid = (count != 2'd0);
  assign result = entry[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      tail <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[tail] <= push_data;
    end
  end

endmodule

### hdl/scanline_parity_fill_counter_core.sv
// Latency: a result is offered in the cycle after the pixel transfer that causes it,
// if no earlier result is waiting. Throughput: one pixel per cycle; the column, row
// and span state update is combinational logic. A two-entry result buffer rides out
// short output stalls, and pixels are held off only while both entries are waiting.
// Reset clears the counters, flags, total and result buffer and sets row_width to 640.
module scanline_parity_fill_counter_core #(
  parameter int MAX_WIDTH = spfc_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  spfc_pkg::pixel_t  pixel,
  output logic              result_valid,
  input  logic              result_ready,
  output spfc_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [spfc_pkg::ROW_WIDTH_W-1:0] row_width;
  logic [COL_W-1:0]                 column_pos;
  logic [COL_W-1:0]                 column_pos_next;
  logic [spfc_pkg::POS_W-1:0]       row_pos;
  logic [spfc_pkg::POS_W-1:0]       row_pos_next;
  spfc_pkg::row_flags_t             flags;
  spfc_pkg::row_flags_t             flags_next;
  logic [COL_W-1:0]                 open_start;
  logic [COL_W-1:0]                 open_start_next;
  logic [spfc_pkg::TOTAL_W-1:0]     pixel_total;
  logic [spfc_pkg::TOTAL_W-1:0]     pixel_total_next;
  logic                             has_result;
  spfc_pkg::result_t                step_result;
  logic                             take;
  logic                             space;
  logic [1:0]                       addr_unused;

  assign pready = 1'b1;
  assign addr_unused = paddr;
  assign prdata = 32'(row_width);
  assign pixel_ready = space;
  assign take = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= spfc_pkg::ROW_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && (addr_unused == paddr)) begin
      row_width <= pwdata[spfc_pkg::ROW_WIDTH_W-1:0];
    end
  end

  spfc_step #(
    .MAX_WIDTH(MAX_WIDTH),
    .COL_W(COL_W)
  ) u_step (
    .pixel(pixel),
    .row_width(row_width),
    .column_pos(column_pos),
    .row_pos(row_pos),
    .flags(flags),
    .open_start(open_start),
    .pixel_total(pixel_total),
    .column_pos_next(column_pos_next),
    .row_pos_next(row_pos_next),
    .flags_next(flags_next),
    .open_start_next(open_start_next),
    .pixel_total_next(pixel_total_next),
    .has_result(has_result),
    .result(step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos <= '0;
      flags <= '0;
      open_start <= '0;
      pixel_total <= '0;
    end else if (take) begin
      column_pos <= column_pos_next;
      row_pos <= row_pos_next;
      flags <= flags_next;
      open_start <= open_start_next;
      pixel_total <= pixel_total_next;
    end
  end

  spfc_out_buf u_out_buf (
    .clk(clk),
    .rst(rst),
    .push(take && has_result),
    .push_data(step_result),
    .space(space),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

endmodule

### bench/tb_scanline_parity_fill_counter_core.sv
`timescale 1ns / 100ps

module tb_scanline_parity_fill_counter_core;

  localparam logic [1:0] CLASS_WHITE = 2'd1;
  localparam logic [1:0] CLASS_SPARE = 2'd3;
  localparam logic [1:0] ROW_WIDTH_ADDR = 2'd0;
  localparam int DRAIN_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRESSURE_AT = 600;
  localparam int PRESSURE_LEN = 300;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_ready;
  spfc_pkg::pixel_t pixel = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  spfc_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  scanline_parity_fill_counter_core DUT (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel(pixel),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  spfc_pkg::pixel_t pixel_queue[$];
  spfc_pkg::result_t fill_expect[$];
  logic [1:0] pattern_q[$];

  logic [12:0] cur_width;
  logic [11:0] col_pos;
  logic [11:0] row_pos;
  logic [11:0] span_start;
  logic [23:0] fill_count;
  spfc_pkg::row_flags_t flags;

  int mismatches = 0;
  int quiet_cycles = 0;
  logic calm = 1'b0;
  int tx_gap = 0;
  int tx_run = 0;
  int rx_gap = 0;
  int rx_run = 0;
  int hold_left = 0;
  int seen_pixels = 0;
  logic pressure_done = 1'b0;

  function automatic int burst_free_run();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 20);
  endfunction

  // Runs one accepted pixel through the span tracker and queues the result it causes.
  function automatic void advance_fill(input spfc_pkg::pixel_t px);
    spfc_pkg::result_t r;
    logic closed;
    logic after_outline;
    logic [24:0] sum;
    int eff;
    r = '0;
    closed = 1'b0;
    eff = (cur_width < 13'd2) ? 2 :
          (int'(cur_width) > spfc_pkg::MAX_WIDTH_DEFAULT) ? spfc_pkg::MAX_WIDTH_DEFAULT :
          int'(cur_width);
    after_outline = (col_pos != '0) && flags.prev_was_outline;
    if (px.pixel_class == spfc_pkg::CLASS_OUTLINE) begin
      if (flags.inside_flag) begin
        flags.inside_flag = 1'b0;
        flags.entering_flag = 1'b0;
        if (span_start != '0) begin
          closed = 1'b1;
          r.span_row = row_pos;
          r.span_first = span_start;
          r.span_stop = col_pos;
          if (col_pos > span_start) begin
            sum = {1'b0, fill_count} + 25'(col_pos - span_start);
            fill_count = sum[24] ? spfc_pkg::TOTAL_MAX : sum[23:0];
          end
          span_start = '0;
        end
      end else begin
        flags.entering_flag = 1'b1;
      end
    end
    if (after_outline && px.pixel_class == spfc_pkg::CLASS_BLACK && flags.entering_flag) begin
      flags.inside_flag = 1'b1;
      span_start = col_pos;
    end
    flags.prev_was_outline = (px.pixel_class == spfc_pkg::CLASS_OUTLINE);
    if (closed || px.last_pixel) begin
      r.span_valid = closed;
      r.filled_total = fill_count;
      r.image_done = px.last_pixel;
      fill_expect = {fill_expect, r};
    end
    if (px.last_pixel) begin
      col_pos = '0;
      row_pos = '0;
      fill_count = '0;
      flags = '0;
      span_start = '0;
    end else if (int'(col_pos) + 1 >= eff) begin
      col_pos = '0;
      row_pos = row_pos + 12'd1;
      flags = '0;
      span_start = '0;
    end else begin
      col_pos = col_pos + 12'd1;
    end
  endfunction

  function automatic logic [1:0] next_class();
    int pick;
    if (pattern_q.size() == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          pattern_q = {pattern_q, spfc_pkg::CLASS_OUTLINE};
          pattern_q = {pattern_q, spfc_pkg::CLASS_BLACK};
          repeat ($urandom_range(0, 6)) begin
            pick = $urandom_range(0, 2);
            pattern_q = {pattern_q,
                         pick == 0 ? spfc_pkg::CLASS_BLACK : pick == 1 ? CLASS_WHITE : CLASS_SPARE};
          end
          pattern_q = {pattern_q, spfc_pkg::CLASS_OUTLINE};
        end
        6, 7, 8: begin
          pattern_q = {pattern_q, 2'($urandom_range(0, 3))};
        end
        default: begin
          pattern_q = {pattern_q, spfc_pkg::CLASS_OUTLINE};
          pattern_q = {pattern_q, CLASS_WHITE};
          pattern_q = {pattern_q, spfc_pkg::CLASS_BLACK};
        end
      endcase
    end
    return pattern_q.pop_front();
  endfunction

  task automatic queue_pixel(input logic [1:0] cls, input logic last);
    spfc_pkg::pixel_t px;
    px.pixel_class = cls;
    px.last_pixel = last;
    pixel_queue = {pixel_queue, px};
  endtask

  task automatic queue_images(input int budget);
    int npix;
    while (budget > 0) begin
      npix = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 300) : $urandom_range(1, 60);
      if (npix > budget) npix = budget;
      for (int i = 0; i < npix; i++) queue_pixel(next_class(), i == npix - 1);
      budget -= npix;
    end
  endtask

  task automatic apb_cycle(input logic wr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ROW_WIDTH_ADDR;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_row_width(input logic [12:0] w);
    apb_cycle(1'b0, $urandom());
    apb_cycle(1'b1, {19'($urandom()), w});
    apb_cycle(1'b0, $urandom());
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || pixel_valid || fill_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pixel_ready) begin
      if (!calm && tx_gap > 0) begin
        tx_gap--;
        pixel_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        pixel <= pixel_queue.pop_front();
        pixel_valid <= 1'b1;
        if (tx_run > 0) begin
          tx_run--;
        end else if (!calm) begin
          tx_gap = $urandom_range(1, 8);
          tx_run = burst_free_run();
        end
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (pixel_valid && pixel_ready) seen_pixels++;
      if (seen_pixels == PRESSURE_AT && !pressure_done) begin
        hold_left = PRESSURE_LEN;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (!calm && rx_gap > 0) begin
        rx_gap--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if (rx_run > 0) begin
          rx_run--;
        end else if (!calm) begin
          rx_gap = $urandom_range(1, 8);
          rx_run = burst_free_run();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cur_width = spfc_pkg::ROW_WIDTH_RESET;
      col_pos = '0;
      row_pos = '0;
      span_start = '0;
      fill_count = '0;
      flags = '0;
    end else begin
      if ((pixel_valid && pixel_ready) || (result_valid && result_ready) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          cur_width = pwdata[12:0];
        end else if (prdata !== {19'd0, cur_width}) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("row_width read mismatch: expected %0d, got %0d", cur_width, prdata);
          end
        end
      end
      if (result_valid && result_ready) begin
        if (fill_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected result transfer: span=%0d row=%0d first=%0d stop=%0d",
                     result.span_valid, result.span_row, result.span_first, result.span_stop);
          end
        end else if (result.span_valid !== fill_expect[0].span_valid ||
                     result.span_row !== fill_expect[0].span_row ||
                     result.span_first !== fill_expect[0].span_first ||
                     result.span_stop !== fill_expect[0].span_stop ||
                     result.filled_total !== fill_expect[0].filled_total ||
                     result.image_done !== fill_expect[0].image_done) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result mismatch: expected span=%0d row=%0d first=%0d stop=%0d %s",
                     fill_expect[0].span_valid, fill_expect[0].span_row,
                     fill_expect[0].span_first, fill_expect[0].span_stop, "");
            $display("  expected total=%0d done=%0d",
                     fill_expect[0].filled_total, fill_expect[0].image_done);
            $display("  actual   span=%0d row=%0d first=%0d stop=%0d total=%0d done=%0d",
                     result.span_valid, result.span_row, result.span_first, result.span_stop,
                     result.filled_total, result.image_done);
          end
          void'(fill_expect.pop_front());
        end else begin
          void'(fill_expect.pop_front());
        end
      end
      if (pixel_valid && pixel_ready) advance_fill(pixel);
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("scanline_parity_fill_counter_core verification failed");
    $finish;
  end

  initial begin
    logic [12:0] sweep [11];
    sweep = '{13'd0, 13'd1, 13'd2, 13'd3, 13'd4, 13'd7, 13'd16, 13'd37,
              13'd640, 13'd5000, 13'd8191};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Short rows of eight: spans that close, a span left open across a row wrap,
    // a black pixel at column zero right after an outline, and two images back to back.
    set_row_width(13'd8);
    queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b0); queue_pixel(spfc_pkg::CLASS_BLACK, 1'b0);
    queue_pixel(CLASS_SPARE, 1'b0); queue_pixel(CLASS_WHITE, 1'b0);
    queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b0); queue_pixel(spfc_pkg::CLASS_BLACK, 1'b0);
    queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b0); queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b0);
    queue_pixel(spfc_pkg::CLASS_BLACK, 1'b0); queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b0);
    queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b0); queue_pixel(spfc_pkg::CLASS_BLACK, 1'b0);
    queue_pixel(spfc_pkg::CLASS_BLACK, 1'b0); queue_pixel(spfc_pkg::CLASS_BLACK, 1'b0);
    queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b0); queue_pixel(spfc_pkg::CLASS_BLACK, 1'b0);
    queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b0);
    for (int c = 1; c < 8; c++) queue_pixel(spfc_pkg::CLASS_BLACK, 1'b0);
    queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b0); queue_pixel(spfc_pkg::CLASS_BLACK, 1'b1);
    queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b0); queue_pixel(spfc_pkg::CLASS_BLACK, 1'b0);
    queue_pixel(spfc_pkg::CLASS_OUTLINE, 1'b1);
    drain();

    foreach (sweep[i]) begin
      set_row_width(sweep[i]);
      queue_images(150);
      drain();
    end

    calm <= 1'b1;
    set_row_width(13'($urandom_range(2, 64)));
    queue_images(200);
    drain();

    if (mismatches == 0 && fill_expect.size() == 0) begin
      $display("scanline_parity_fill_counter_core verification clean");
    end else begin
      $display("scanline_parity_fill_counter_core verification failed");
    end
    $finish;
  end

endmodule
